@@ hw/rtl/zrvd_pkg.sv @@
// Shared types and constants of the zero-run visibility decoder.
`default_nettype none

package zrvd_pkg;

    localparam int LEAF_COUNT_W = 13;
    localparam int MAX_ROW_BYTES_DEFAULT = 512;
    localparam logic [LEAF_COUNT_W-1:0] LEAF_COUNT_RESET = 13'd4096;
    localparam logic [7:0] ALL_ONES_BYTE = 8'hff;
    localparam logic [7:0] ZERO_BYTE = 8'h00;
    localparam int QUEUE_DEPTH = 2;
    localparam int WORD_BYTES = 8;

    // Work orders passed from the front part to the back part.
    typedef enum logic [1:0] {
        OP_LIT,
        OP_RUN,
        OP_ONES
    } zrvd_op_t;

    typedef struct packed {
        zrvd_op_t   op;
        logic [7:0] byte_val;
    } zrvd_cmd_t;

    // Head of the queue as seen by the back part.
    typedef struct packed {
        logic      valid;
        zrvd_cmd_t cmd;
    } zrvd_head_t;

endpackage : zrvd_pkg

`default_nettype wire

@@ hw/rtl/zrvd_in_if.sv @@
// Input channel of the decoder: one compressed byte or command per item.
`default_nettype none

interface zrvd_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] data_byte;

    modport source (output valid, output cmd, output data_byte, input ready);
    modport sink (input valid, input cmd, input data_byte, output ready);
endinterface : zrvd_in_if

`default_nettype wire

@@ hw/rtl/zrvd_out_if.sv @@
// Output channel of the decoder: one packed word of decoded bytes per item.
`default_nettype none

interface zrvd_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] data_word;
    logic [3:0]  valid_bytes;
    logic        last_of_row;
    logic        overrun;

    modport source (output valid, output data_word, output valid_bytes,
                    output last_of_row, output overrun, input ready);
    modport sink (input valid, input data_word, input valid_bytes,
                  input last_of_row, input overrun, output ready);
endinterface : zrvd_out_if

`default_nettype wire

@@ hw/rtl/zrvd_queue.sv @@
// Short command queue between the front and back parts of the decoder.
`default_nettype none

module zrvd_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               flush,
    input  wire logic               push,
    input  wire zrvd_pkg::zrvd_cmd_t push_cmd,
    output logic                    full,
    input  wire logic               pop,
    output zrvd_pkg::zrvd_head_t    head
);
    import zrvd_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    zrvd_cmd_t              entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   do_push, do_pop;

    assign full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && (count_reg != '0);

    assign head.valid = (count_reg != '0);
    assign head.cmd   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
        if (flush)
        begin
            wr_ptr_next = '0;
            rd_ptr_next = '0;
            count_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule : zrvd_queue

`default_nettype wire

@@ hw/rtl/zrvd_front.sv @@
// Front part: accepts input items and turns them into decode commands.
`default_nettype none

module zrvd_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                restart,
    zrvd_in_if.sink                  stream,
    input  wire logic                queue_full,
    output logic                     push,
    output zrvd_pkg::zrvd_cmd_t      push_cmd
);
    import zrvd_pkg::*;

    logic expect_run_reg, expect_run_next;
    logic accept;

    assign stream.ready = !queue_full;
    assign accept       = stream.valid && stream.ready;

    always_comb
    begin
        expect_run_next   = expect_run_reg;
        push              = 1'b0;
        push_cmd.op       = OP_LIT;
        push_cmd.byte_val = stream.data_byte;
        if (accept)
        begin
            if (stream.cmd)
            begin
                // The all-ones row drops a pending run count.
                push            = 1'b1;
                push_cmd.op     = OP_ONES;
                expect_run_next = 1'b0;
            end
            else if (expect_run_reg)
            begin
                push            = 1'b1;
                push_cmd.op     = OP_RUN;
                expect_run_next = 1'b0;
            end
            else if (stream.data_byte != ZERO_BYTE)
            begin
                push        = 1'b1;
                push_cmd.op = OP_LIT;
            end
            else
            begin
                expect_run_next = 1'b1;
            end
        end
        if (restart)
        begin
            expect_run_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expect_run_reg <= 1'b0;
        end
        else
        begin
            expect_run_reg <= expect_run_next;
        end
    end

endmodule : zrvd_front

`default_nettype wire

@@ hw/rtl/zrvd_back.sv @@
// Back part: executes decode commands and packs bytes into output words.
`default_nettype none

module zrvd_back #(
    parameter int MAX_ROW_BYTES = zrvd_pkg::MAX_ROW_BYTES_DEFAULT
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_wr_en,
    input  wire logic [zrvd_pkg::LEAF_COUNT_W-1:0] cfg_wr_data,
    input  wire zrvd_pkg::zrvd_head_t             head,
    output logic                                  pop,
    zrvd_out_if.source                            words
);
    import zrvd_pkg::*;

    localparam int LEN_W = $clog2(MAX_ROW_BYTES + 1);
    localparam int CNT_W = (LEN_W > 8) ? LEN_W : 8;
    localparam int SUM_W = LEAF_COUNT_W + 1;

    logic [LEN_W-1:0]  row_len_reg;
    logic [LEN_W-1:0]  row_len_cfg;
    logic [SUM_W-1:0]  leaf_sum;
    logic [SUM_W-1:0]  len_raw;

    logic              busy_reg;
    zrvd_op_t          op_reg;
    logic [CNT_W-1:0]  left_reg;
    logic              clip_reg;
    logic [63:0]       acc_reg;
    logic [2:0]        fill_reg;
    logic [LEN_W-1:0]  row_pos_reg;

    logic              out_valid_reg;
    logic [63:0]       out_word_reg;
    logic [3:0]        out_bytes_reg;
    logic              out_last_reg;
    logic              out_overrun_reg;

    logic              step;
    zrvd_op_t          cur_op;
    logic [CNT_W-1:0]  cur_left;
    logic              cur_clip;
    logic [63:0]       cur_acc;
    logic [2:0]        cur_fill;
    logic [LEN_W-1:0]  cur_row_pos;
    logic [LEN_W-1:0]  remaining;
    logic [3:0]        space;
    logic [3:0]        n_bytes;
    logic [3:0]        new_fill;
    logic [LEN_W:0]    row_sum;
    logic              row_end;
    logic              word_done;
    logic [7:0]        fill_val;
    logic [63:0]       acc_new;
    logic [CNT_W-1:0]  left_new;

    // Row length from the leaf count, saturated and never zero.
    assign leaf_sum = SUM_W'(cfg_wr_data) + SUM_W'(7);
    assign len_raw  = leaf_sum >> 3;
    always_comb
    begin
        if (len_raw > SUM_W'(MAX_ROW_BYTES))
        begin
            row_len_cfg = LEN_W'(MAX_ROW_BYTES);
        end
        else if (len_raw == '0)
        begin
            row_len_cfg = LEN_W'(1);
        end
        else
        begin
            row_len_cfg = len_raw[LEN_W-1:0];
        end
    end

    assign step = (busy_reg || head.valid) && (!out_valid_reg || words.ready);
    assign pop  = step && !busy_reg;

    // The first step of a command works straight off the queue head.
    always_comb
    begin
        cur_op      = busy_reg ? op_reg : head.cmd.op;
        cur_acc     = acc_reg;
        cur_fill    = fill_reg;
        cur_row_pos = row_pos_reg;
        cur_left    = left_reg;
        cur_clip    = clip_reg;
        remaining   = row_len_reg - row_pos_reg;
        if (!busy_reg)
        begin
            case (head.cmd.op)
                OP_RUN:
                begin
                    cur_clip = CNT_W'(head.cmd.byte_val) > CNT_W'(remaining);
                    cur_left = cur_clip ? CNT_W'(remaining) : CNT_W'(head.cmd.byte_val);
                end
                OP_ONES:
                begin
                    // A new all-ones row throws away any partial row.
                    cur_acc     = '0;
                    cur_fill    = '0;
                    cur_row_pos = '0;
                    cur_left    = CNT_W'(row_len_reg);
                    cur_clip    = 1'b0;
                end
                default:
                begin
                    cur_left = CNT_W'(1);
                    cur_clip = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        space    = 4'd8 - {1'b0, cur_fill};
        n_bytes  = (cur_left < CNT_W'(space)) ? cur_left[3:0] : space;
        new_fill = {1'b0, cur_fill} + n_bytes;
        row_sum  = (LEN_W+1)'(cur_row_pos) + (LEN_W+1)'(n_bytes);
        row_end  = row_sum >= (LEN_W+1)'(row_len_reg);
        word_done = (new_fill == 4'd8) || row_end;
        left_new = cur_left - CNT_W'(n_bytes);
        case (cur_op)
            OP_LIT:  fill_val = head.cmd.byte_val;
            OP_ONES: fill_val = ALL_ONES_BYTE;
            default: fill_val = ZERO_BYTE;
        endcase
        for (int b = 0; b < WORD_BYTES; b++)
        begin
            if ((4'(b) >= {1'b0, cur_fill}) && (4'(b) < new_fill))
            begin
                acc_new[b*8 +: 8] = fill_val;
            end
            else
            begin
                acc_new[b*8 +: 8] = cur_acc[b*8 +: 8];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_len_reg   <= LEN_W'(MAX_ROW_BYTES);
            busy_reg      <= 1'b0;
            fill_reg      <= '0;
            row_pos_reg   <= '0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            row_len_reg <= row_len_cfg;
            busy_reg    <= 1'b0;
            fill_reg    <= '0;
            row_pos_reg <= '0;
            acc_reg     <= '0;
        end
        else
        begin
            if (step && word_done)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (words.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (step)
            begin
                busy_reg <= (left_new != '0);
                if (word_done)
                begin
                    acc_reg       <= '0;
                    fill_reg      <= '0;
                    row_pos_reg   <= row_end ? '0 : row_sum[LEN_W-1:0];
                end
                else
                begin
                    acc_reg     <= acc_new;
                    fill_reg    <= new_fill[2:0];
                    row_pos_reg <= row_sum[LEN_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            op_reg   <= cur_op;
            left_reg <= left_new;
            clip_reg <= cur_clip;
            if (word_done)
            begin
                out_word_reg    <= acc_new;
                out_bytes_reg   <= new_fill;
                out_last_reg    <= row_end;
                out_overrun_reg <= row_end && cur_clip;
            end
        end
    end

    assign words.valid       = out_valid_reg;
    assign words.data_word   = out_word_reg;
    assign words.valid_bytes = out_bytes_reg;
    assign words.last_of_row = out_last_reg;
    assign words.overrun     = out_overrun_reg;

endmodule : zrvd_back

`default_nettype wire

@@ hw/rtl/zero_run_visibility_decoder_top.sv @@
// Top level of the zero-run visibility decoder.
// The stream channel takes one item per transfer: cmd 0 carries a compressed
// byte, cmd 1 asks for a whole row of 0xff bytes. The words channel returns
// packed 64-bit words, first byte in the lowest bits, with the count of valid
// bytes, a flag on the last word of each row and an overrun flag when a zero
// run was clipped at the row end.
// The back part adds a literal byte to the word it packs; it fills a zero run
// or an all-ones row word by word, taking no new command until it is done.
// A word appears on the words channel the cycle after the step completing it.
// A two-entry command queue keeps the input flowing while the back part
// works through runs, so input stalls only when that queue is full.
// The output word sits in a register; while the receiver holds ready low,
// the back part waits and the queue fills, then the stream is held off.
// Writing leaf_count sets the row length and restarts decoding from a row
// start. Reset sets a row length of MAX_ROW_BYTES and an empty pipeline.
`default_nettype none

module zero_run_visibility_decoder_top #(
    parameter int MAX_ROW_BYTES = zrvd_pkg::MAX_ROW_BYTES_DEFAULT
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_wr_en,
    input  wire logic [zrvd_pkg::LEAF_COUNT_W-1:0] cfg_wr_data,
    zrvd_in_if.sink                                stream,
    zrvd_out_if.source                             words
);
    import zrvd_pkg::*;

    logic       push;
    zrvd_cmd_t  push_cmd;
    logic       queue_full;
    logic       pop;
    zrvd_head_t head;

    zrvd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .restart    (cfg_wr_en),
        .stream     (stream),
        .queue_full (queue_full),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    zrvd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .flush    (cfg_wr_en),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (queue_full),
        .pop      (pop),
        .head     (head)
    );

    zrvd_back #(
        .MAX_ROW_BYTES (MAX_ROW_BYTES)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .head        (head),
        .pop         (pop),
        .words       (words)
    );

endmodule : zero_run_visibility_decoder_top

`default_nettype wire

@@ hw/rtl/zrvd_checker.sv @@
// Port-level checker for the zero-run visibility decoder and its binding.
`default_nettype none

module zrvd_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [63:0] out_word,
    input wire logic [3:0]  out_bytes,
    input wire logic        out_last,
    input wire logic        out_overrun
);

    // Only the last word of a row may be partly filled.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_last) |-> (out_bytes == 4'd8))
        else $error("short word without end of row");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_bytes != 4'd0) && (out_bytes <= 4'd8))
        else $error("valid byte count out of range");

    // A clipped run always ends on a row boundary.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_overrun) |-> out_last)
        else $error("overrun flagged away from the row end");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(out_word) && $stable(out_bytes)))
        else $error("stalled output word changed");

endmodule : zrvd_checker

bind zero_run_visibility_decoder_top zrvd_checker u_zrvd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (words.valid),
    .out_ready   (words.ready),
    .out_word    (words.data_word),
    .out_bytes   (words.valid_bytes),
    .out_last    (words.last_of_row),
    .out_overrun (words.overrun)
);

`default_nettype wire

@@ dv/zero_run_visibility_decoder_top_test.sv @@
// Self-checking testbench for the zero-run visibility decoder: directed and random streams.
module zero_run_visibility_decoder_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import zrvd_pkg::*;

    localparam logic CMD_DATA = 1'b0;
    localparam logic CMD_NO_VIS = 1'b1;
    localparam int unsigned ROW_LIMIT = MAX_ROW_BYTES_DEFAULT;
    localparam int unsigned GAP_PERCENT = 12;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned DRAIN_CYCLES = 24;
    localparam int unsigned PHASE_ITEMS = 23;

    typedef struct {
        logic       cmd;
        logic [7:0] data;
    } stream_item_t;

    typedef struct packed {
        logic [63:0] data_word;
        logic [3:0]  valid_bytes;
        logic        last_of_row;
        logic        overrun;
    } visibility_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [LEAF_COUNT_W-1:0] cfg_wr_data = '0;
    logic in_valid = 1'b0;
    logic in_cmd = CMD_DATA;
    logic [7:0] in_byte = ZERO_BYTE;
    logic out_ready = 1'b0;

    zrvd_in_if stream_ch ();
    zrvd_out_if word_ch ();

    assign stream_ch.valid = in_valid;
    assign stream_ch.cmd = in_cmd;
    assign stream_ch.data_byte = in_byte;
    assign word_ch.ready = out_ready;

    zero_run_visibility_decoder_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .stream     (stream_ch),
        .words      (word_ch)
    );

    stream_item_t     stream_items[$];
    visibility_word_t due_words[$];
    int unsigned      mismatches = 0;
    bit               no_gaps = 1'b0;
    bit               hold_request = 1'b0;
    bit               hold_taken = 1'b0;
    int unsigned      hold_left = 0;

    // Decoder state as the block should hold it.
    logic [LEAF_COUNT_W-1:0] leaf_count = LEAF_COUNT_RESET;
    logic [63:0]             gathered = '0;
    int unsigned             gathered_bytes = 0;
    int unsigned             row_pos = 0;
    bit                      run_next = 1'b0;

    function automatic int unsigned row_bytes();
        int unsigned len;
        len = (32'(leaf_count) + 7) >> 3;
        if (len > ROW_LIMIT)
            len = ROW_LIMIT;
        if (len == 0)
            len = 1;
        return len;
    endfunction

    function automatic void restart_row();
        gathered = '0;
        gathered_bytes = 0;
        row_pos = 0;
        run_next = 1'b0;
    endfunction

    function automatic void emit_byte(input logic [7:0] value, input bit clipped);
        bit row_end;
        gathered = gathered | (64'(value) << (gathered_bytes * 8));
        gathered_bytes++;
        row_pos++;
        row_end = (row_pos >= row_bytes());
        if (gathered_bytes >= WORD_BYTES || row_end) begin
            due_words.push_back('{gathered, 4'(gathered_bytes), row_end, row_end && clipped});
            gathered = '0;
            gathered_bytes = 0;
            if (row_end)
                row_pos = 0;
        end
    endfunction

    function automatic void expand_item(input logic cmd, input logic [7:0] value);
        int unsigned remaining;
        int unsigned run;
        int unsigned len;
        bit clipped;
        if (cmd == CMD_NO_VIS) begin
            restart_row();
            len = row_bytes();
            for (int unsigned i = 0; i < len; i++)
                emit_byte(ALL_ONES_BYTE, 1'b0);
        end else if (run_next) begin
            remaining = row_bytes() - row_pos;
            run = value;
            clipped = 1'b0;
            run_next = 1'b0;
            if (run > remaining) begin
                run = remaining;
                clipped = 1'b1;
            end
            for (int unsigned i = 0; i < run; i++)
                emit_byte(ZERO_BYTE, clipped);
        end else if (value != ZERO_BYTE) begin
            emit_byte(value, 1'b0);
        end else begin
            run_next = 1'b1;
        end
    endfunction

    function automatic void queue_item(input logic cmd, input logic [7:0] value);
        stream_items.push_back('{cmd, value});
    endfunction

    // Mostly literals and well-formed zero runs; the rest is all-ones rows and noise.
    task automatic queue_random_stream(input int unsigned count);
        int unsigned queued;
        int unsigned pick;
        int unsigned span;
        queued = 0;
        while (queued < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                queue_item(CMD_DATA, 8'($urandom_range(1, 255)));
                queued += 1;
            end else if (pick < 85) begin
                span = row_bytes() + 2;
                if (span > 255)
                    span = 255;
                queue_item(CMD_DATA, ZERO_BYTE);
                if ($urandom_range(0, 3) == 0)
                    queue_item(CMD_DATA, 8'($urandom_range(0, 255)));
                else
                    queue_item(CMD_DATA, 8'($urandom_range(0, span)));
                queued += 2;
            end else if (pick < 92) begin
                queue_item(CMD_NO_VIS, 8'($urandom_range(0, 255)));
                queued += 1;
            end else begin
                queue_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
                queued += 1;
            end
        end
    endtask

    // Wait until every item has gone in and every word has come out, then let
    // the block finish any item that leaves no word behind.
    task automatic settle();
        while (stream_items.size() != 0 || in_valid || due_words.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_leaf_count(input logic [LEAF_COUNT_W-1:0] value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        leaf_count = value;
        restart_row();
    endtask

    initial begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk or negedge rst_n) begin : drive_stream
        stream_item_t next_item;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && stream_ch.ready)
                expand_item(in_cmd, in_byte);
            if (!in_valid || stream_ch.ready) begin
                if (stream_items.size() != 0
                        && (no_gaps || $urandom_range(0, 99) >= GAP_PERCENT)) begin
                    next_item = stream_items.pop_front();
                    in_valid <= 1'b1;
                    in_cmd <= next_item.cmd;
                    in_byte <= next_item.data;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // One long hold-off lets the command queue fill and back-pressure the stream.
    always @(posedge clk or negedge rst_n) begin : hold_receiver
        if (!rst_n) begin
            hold_left <= 0;
        end else if (hold_request && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge clk or negedge rst_n) begin : watch_words
        visibility_word_t got;
        visibility_word_t want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (word_ch.valid && out_ready) begin
                got = '{word_ch.data_word, word_ch.valid_bytes, word_ch.last_of_row,
                        word_ch.overrun};
                if (due_words.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected word: data %h bytes %0d last %0b overrun %0b",
                                 got.data_word, got.valid_bytes, got.last_of_row, got.overrun);
                end else begin
                    want = due_words.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"word mismatch: expected data %h bytes %0d last %0b ",
                                      "overrun %0b, got data %h bytes %0d last %0b overrun %0b"},
                                     want.data_word, want.valid_bytes, want.last_of_row,
                                     want.overrun, got.data_word, got.valid_bytes,
                                     got.last_of_row, got.overrun);
                    end
                end
            end
            if (hold_left != 0)
                out_ready <= 1'b0;
            else
                out_ready <= no_gaps || ($urandom_range(0, 99) >= GAP_PERCENT);
        end
    end

    initial begin
        #5_000_000;
        $display("zero_run_visibility_decoder_top: mismatch");
        $finish;
    end

    initial begin : run_phases
        logic [LEAF_COUNT_W-1:0] phase_leaves[7];
        phase_leaves = '{13'd1, 13'd64, 13'd8191, 13'd9, 13'd40, 13'd4088, 13'd4096};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Reset row length of 512 bytes: literals, empty and long runs, all-ones
        // rows that drop a partial row and a pending run count.
        queue_item(CMD_DATA, 8'h01);
        queue_item(CMD_DATA, 8'hff);
        queue_item(CMD_DATA, 8'h80);
        queue_item(CMD_DATA, ZERO_BYTE);
        queue_item(CMD_DATA, 8'h00);
        queue_item(CMD_DATA, ZERO_BYTE);
        queue_item(CMD_DATA, 8'hff);
        queue_item(CMD_DATA, 8'h7f);
        queue_item(CMD_NO_VIS, 8'h00);
        queue_item(CMD_DATA, 8'h55);
        queue_item(CMD_NO_VIS, 8'ha5);
        queue_item(CMD_DATA, ZERO_BYTE);
        queue_item(CMD_NO_VIS, 8'hff);
        queue_item(CMD_DATA, ZERO_BYTE);
        queue_item(CMD_DATA, 8'h01);
        settle();

        // Three-byte rows: a clipped run, then a run that ends exactly at the row end.
        write_leaf_count(13'd20);
        queue_item(CMD_DATA, 8'h11);
        queue_item(CMD_DATA, ZERO_BYTE);
        queue_item(CMD_DATA, 8'hff);
        queue_item(CMD_DATA, 8'h22);
        queue_item(CMD_DATA, ZERO_BYTE);
        queue_item(CMD_DATA, 8'h02);
        settle();

        // A leaf count of zero still gives one-byte rows.
        write_leaf_count(13'd0);
        queue_item(CMD_DATA, 8'h33);
        queue_item(CMD_DATA, ZERO_BYTE);
        queue_item(CMD_DATA, 8'h01);
        queue_item(CMD_NO_VIS, 8'h5a);
        settle();

        for (int i = 0; i < 9; i++) begin
            if (i < 7)
                write_leaf_count(phase_leaves[i]);
            else
                write_leaf_count(13'($urandom_range(2, 300)));
            no_gaps = (i == 1);
            if (i == 4)
                hold_request = 1'b1;
            queue_random_stream(PHASE_ITEMS);
            settle();
        end
        no_gaps = 1'b0;

        if (due_words.size() != 0)
            mismatches++;
        if (mismatches == 0)
            $display("zero_run_visibility_decoder_top: match");
        else
            $display("zero_run_visibility_decoder_top: mismatch");
        $finish;
    end

endmodule
